/* rtl/core/lsh_pkg.sv */
// ----------------------------------------------------------------------------
// lsh_pkg
// Types and constants shared by the log-spaced histogram modules.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam int NUM_BINS    = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int MAX_EDGES   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int BIN_W   = 3;
   localparam int IDX_W   = $clog2(NUM_BINS);
   localparam int BOUND_W = 63;
   localparam int CSR_W   = 3;

   localparam logic [BOUND_W-1:0] INF_BITS = 63'h7FF0_0000_0000_0000;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   localparam logic [CSR_W-1:0] CSR_LOWER     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_UPPER     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_EDGE_BASE = 3'd2;

   typedef enum logic [2:0] {
      OP_COUNT,
      OP_READ,
      OP_CLEAR,
      OP_ZERO,
      OP_GAP
   } op_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [63:0]      sample_value;
      logic [BIN_W-1:0] bin_select;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin_hit;
      logic             was_counted;
      logic             gap_flag;
      logic [31:0]      bin_count;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [BIN_W-1:0] bin;
   } queue_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/lsh_front.sv */
// ----------------------------------------------------------------------------
// lsh_front
// Holds the bin edges and turns each request into a queue item: the
// operation and, for samples, the bin found by parallel edge compares.
// ----------------------------------------------------------------------------
module lsh_front import lsh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_W-1:0]     csr_index,
   input  logic [BOUND_W-1:0]   csr_data,
   input  req_type              req_data,
   output queue_item_type       item
);

   logic [BOUND_W-1:0] lower_ff;
   logic [BOUND_W-1:0] upper_ff;
   logic [BOUND_W-1:0] bound_edge_ff [MAX_EDGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
         for (int i = 0; i < MAX_EDGES; i++) begin
            bound_edge_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == CSR_LOWER) begin
            lower_ff <= csr_data;
         end else if (csr_index == CSR_UPPER) begin
            upper_ff <= csr_data;
         end else begin
            bound_edge_ff[csr_index - CSR_EDGE_BASE] <= csr_data;
         end
      end
   end

   logic [63:0]      sample;
   logic             is_nan;
   logic             inner_found;
   logic [BIN_W-1:0] inner_bin;

   assign sample = req_data.sample_value;
   assign is_nan = sample[BOUND_W-1:0] > INF_BITS;

   always_comb begin
      inner_found = 1'b0;
      inner_bin   = '0;
      for (int i = NUM_BINS - 2; i >= 1; i--) begin
         if (sample < {1'b0, bound_edge_ff[i-1]}) begin
            inner_found = 1'b1;
            inner_bin   = BIN_W'(i);
         end
      end
   end

   always_comb begin
      item.op  = OP_ZERO;
      item.bin = '0;
      unique case (req_data.action)
         ACT_ADD: begin
            if (is_nan) begin
               item.op = OP_ZERO;
            end else if (sample[63] || sample < {1'b0, lower_ff}) begin
               item.op = OP_COUNT;
            end else if (sample >= {1'b0, upper_ff}) begin
               item.op  = OP_COUNT;
               item.bin = BIN_W'(NUM_BINS - 1);
            end else if (inner_found) begin
               item.op  = OP_COUNT;
               item.bin = inner_bin;
            end else begin
               item.op = OP_GAP;
            end
         end
         ACT_READ: begin
            item.op  = OP_READ;
            item.bin = req_data.bin_select;
         end
         ACT_CLEAR: item.op = OP_CLEAR;
         ACT_NOP:   item.op = OP_ZERO;
      endcase
   end

endmodule

/* rtl/core/lsh_queue.sv */
// ----------------------------------------------------------------------------
// lsh_queue
// Short register queue between the classifier and the counter stage.
// ----------------------------------------------------------------------------
module lsh_queue import lsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_item_type   push_item,
   input  logic             pop,
   output queue_item_type   head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/lsh_back.sv */
// ----------------------------------------------------------------------------
// lsh_back
// Counter stage: saturating bin counters, read and clear, result register.
// ----------------------------------------------------------------------------
module lsh_back import lsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  queue_item_type   head,
   output logic             pop,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_BINS];
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [IDX_W-1:0]       idx;
   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] bumped;
   logic [63:0]            bumped_wide;
   logic [63:0]            cur_wide;

   assign pop         = !q_status.empty;
   assign idx         = head.bin[IDX_W-1:0];
   assign cur         = cnt_ff[idx];
   assign bumped      = (cur == CNT_MAX) ? cur : cur + 1'b1;
   assign bumped_wide = 64'(bumped);
   assign cur_wide    = 64'(cur);

   always_comb begin
      rsp_in = '0;
      unique case (head.op)
         OP_COUNT: begin
            rsp_in.bin_hit     = head.bin;
            rsp_in.was_counted = 1'b1;
            rsp_in.bin_count   = bumped_wide[31:0];
         end
         OP_READ: begin
            rsp_in.bin_hit = head.bin;
            if ({1'b0, head.bin} < (BIN_W+1)'(NUM_BINS)) begin
               rsp_in.bin_count = cur_wide[31:0];
            end
         end
         OP_GAP:   rsp_in.gap_flag = 1'b1;
         OP_CLEAR: rsp_in = '0;
         OP_ZERO:  rsp_in = '0;
         default:  rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BINS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= pop;
         if (pop && head.op == OP_COUNT) begin
            cnt_ff[idx] <= bumped;
         end else if (pop && head.op == OP_CLEAR) begin
            for (int i = 0; i < NUM_BINS; i++) begin
               cnt_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/log_spaced_histogram.sv */
// ----------------------------------------------------------------------------
// log_spaced_histogram
// Histogram of double bit patterns into bins bounded by loaded edges.
//
// Channels: a request (req_data) is taken at a clock edge with start high
// and busy low. Each request gives exactly one result, shown on rsp_data for
// one cycle with rsp_valid high; the receiver takes it and cannot stall.
// Edges are written through the csr_ port (csr_ready is always high); the
// user must do so only while no request is in flight, which the block does
// not enforce: index 0 lower bound, 1 upper bound, 2..7 edges. Requests pass
// the queue, then the result register. Throughput: one request per cycle;
// the front classifies with parallel edge compares and the back updates one
// counter per cycle, so the queue never backs up and busy stays low outside
// reset. Reset clears edges, bounds and all counters, and holds busy high.
// ----------------------------------------------------------------------------
module log_spaced_histogram import lsh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_index,
   input  logic [BOUND_W-1:0] csr_data
);

   queue_item_type   item;
   queue_item_type   head;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;
   assign busy      = q_status.full || reset;
   assign push      = start && !busy;

   lsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .item      (item)
   );

   lsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   lsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      push |-> ##2 rsp_valid)
      else $error("accepted item gave no result after two cycles");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full && !pop))
      else $error("queue overflow");

   a_gap_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.gap_flag) |->
         (!rsp_data.was_counted && rsp_data.bin_hit == '0 && rsp_data.bin_count == '0))
      else $error("gap result carries count fields");
`endif

endmodule
